FILE: src/apvn_pkg.sv
package apvn_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;                 // coordinate width
  localparam int QW        = FRAC_BITS + 1;      // quotient bits of a unit component
  localparam int NW        = CW + FRAC_BITS + 1; // dividend width
  localparam int RW        = CW + 1;             // divider remainder width
  localparam int ROWS      = 6;                  // matrix words

  localparam logic [2:0] REG_MODE = 3'd6;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_VECTOR = 2'd1,
    KIND_NORMAL = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_MIXED     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 saturated;
    logic                 zero_normal;
  } out_word_t;

  typedef struct packed {
    logic [ROWS-1:0][63:0] row;
    mode_t                 mode;
  } cfg_t;

  // word passed from the front end to the back end
  typedef struct packed {
    logic [2:0][CW-1:0] r;
    logic               sat;
    logic               norm;
  } mid_t;

  // matrix entry of row r, column col (col 3 is translation)
  function automatic logic signed [CW-1:0] entry(cfg_t c, logic [1:0] r, logic [1:0] col);
    logic [63:0] w;
    w = c.row[3'(r) * 3'd2 + 3'(col[1])];
    return col[0] ? w[63:32] : w[31:0];
  endfunction

endpackage

FILE: src/apvn_front.sv
module apvn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  apvn_pkg::in_word_t item,
  input  apvn_pkg::cfg_t  cfg,
  output logic            push,
  output apvn_pkg::mid_t  word
);
  import apvn_pkg::*;

  localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
  localparam logic signed [66:0]   MAXV = 67'sd2147483647;
  localparam logic signed [66:0]   MINV = -67'sd2147483648;

  logic signed [CW-1:0] coef [3][3];
  logic signed [CW-1:0] tr   [3];
  logic signed [CW-1:0] v    [3];
  kind_t                kind;
  logic                 is_normal;

  logic signed [63:0]   prod [3][3];
  logic signed [CW-1:0] tr_q [3];
  logic                 norm_q;
  logic                 v1;

  logic signed [66:0]   acc  [3];
  mid_t                 word_next;

  // classify the word and pick coefficients and translation
  always_comb begin
    kind      = kind_t'(item.req_type);
    is_normal = (kind == KIND_NORMAL);
    v[0] = item.in_x;
    v[1] = item.in_y;
    v[2] = item.in_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        unique case (cfg.mode)
          MODE_TRANSLATE: coef[i][j] = (i == j) ? ONE : '0;
          MODE_SCALE:     coef[i][j] = (i == j) ? entry(cfg, 2'(i), 2'(i)) : '0;
          default:        coef[i][j] = is_normal ? entry(cfg, 2'(j), 2'(i))
                                                 : entry(cfg, 2'(i), 2'(j));
        endcase
      end
      unique case (cfg.mode)
        MODE_TRANSLATE,
        MODE_MIXED: tr[i] = (kind == KIND_POINT) ? entry(cfg, 2'(i), 2'd3) : '0;
        default:    tr[i] = '0;
      endcase
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) prod[i][j] <= coef[i][j] * v[j];
      tr_q[i] <= tr[i];
    end
    norm_q <= is_normal && (cfg.mode != MODE_TRANSLATE);
  end

  // stage 2: sum, floor shift, translate, clamp
  always_comb begin
    word_next      = '0;
    word_next.norm = norm_q;
    for (int i = 0; i < 3; i++) begin
      acc[i] = ((67'(prod[i][0]) + 67'(prod[i][1]) + 67'(prod[i][2])) >>> FRAC_BITS)
               + 67'(tr_q[i]);
      if (acc[i] > MAXV) begin
        word_next.r[i] = MAXV[CW-1:0];
        word_next.sat  = 1'b1;
      end else if (acc[i] < MINV) begin
        word_next.r[i] = MINV[CW-1:0];
        word_next.sat  = 1'b1;
      end else begin
        word_next.r[i] = acc[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      push <= 1'b0;
    end else begin
      v1   <= accept;
      push <= v1;
    end
  end

  a_push_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 push) else $error("accepted word did not reach the queue");

endmodule

FILE: src/apvn_queue.sv
module apvn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  apvn_pkg::mid_t wdata,
  input  logic           pop,
  output logic           valid,
  output logic           full,
  output apvn_pkg::mid_t rdata
);
  import apvn_pkg::*;

  mid_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       take;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign take  = pop && valid;
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (take) rp <= ~rp;
      count <= count + 2'(push) - 2'(take);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue overflow");

endmodule

FILE: src/apvn_back.sv
module apvn_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  apvn_pkg::mid_t    word,
  output logic              done,
  output apvn_pkg::out_word_t result
);
  import apvn_pkg::*;

  typedef struct packed {
    logic [2:0][CW-1:0] r;
    logic               sat;
    logic               norm;
    logic               zero;
  } side_t;

  // squares
  logic [63:0] sqr [3];
  mid_t        b0_word;
  logic        b0_v;

  // root stages, index 0 is the sum of squares
  logic [63:0] sn [33];
  logic [63:0] sr [33];
  side_t       ss [33];
  logic        sv [33];

  // divider stages, index 0 is the initial remainder
  logic [RW-1:0] dr [QW+1][3];
  logic [QW-1:0] dn [QW+1][3];
  logic [QW-1:0] dq [QW+1][3];
  logic [CW-1:0] dl [QW+1];
  side_t         ds [QW+1];
  logic          dv [QW+1];

  logic [CW-1:0] mag  [3];
  logic [NW-1:0] numer[3];
  out_word_t     result_next;

  // component magnitudes and squares
  always_comb begin
    for (int c = 0; c < 3; c++)
      mag[c] = word.r[c][CW-1] ? CW'(-$signed(word.r[c])) : word.r[c];
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) sqr[c] <= 64'(mag[c]) * 64'(mag[c]);
    b0_word <= word;
  end

  // sum of squares
  always_ff @(posedge clk) begin
    sn[0]      <= sqr[0] + sqr[1] + sqr[2];
    sr[0]      <= '0;
    ss[0].r    <= b0_word.r;
    ss[0].sat  <= b0_word.sat;
    ss[0].norm <= b0_word.norm;
    ss[0].zero <= b0_word.norm && ((sqr[0] | sqr[1] | sqr[2]) == 64'd0);
  end

  // integer square root, one result bit per stage
  for (genvar s = 0; s < 32; s++) begin : g_root
    localparam logic [63:0] BIT = 64'(1) << (2 * (31 - s));
    logic [63:0] trial;
    assign trial = sr[s] + BIT;
    always_ff @(posedge clk) begin
      if (sn[s] >= trial) begin
        sn[s+1] <= sn[s] - trial;
        sr[s+1] <= (sr[s] >> 1) + BIT;
      end else begin
        sn[s+1] <= sn[s];
        sr[s+1] <= sr[s] >> 1;
      end
      ss[s+1] <= ss[s];
    end
  end

  // rounded dividend per component
  always_comb begin
    for (int c = 0; c < 3; c++)
      numer[c] = (NW'(ss[32].r[c][CW-1] ? CW'(-$signed(ss[32].r[c])) : ss[32].r[c])
                  << FRAC_BITS) + NW'(sr[32][CW-1:0] >> 1);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      dr[0][c] <= RW'(numer[c][NW-1:QW]);
      dn[0][c] <= numer[c][QW-1:0];
      dq[0][c] <= '0;
    end
    dl[0] <= sr[32][CW-1:0];
    ds[0] <= ss[32];
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] shifted [3];
    always_comb begin
      for (int c = 0; c < 3; c++) shifted[c] = {dr[k][c][RW-2:0], dn[k][c][QW-1]};
    end
    always_ff @(posedge clk) begin
      for (int c = 0; c < 3; c++) begin
        if (shifted[c] >= RW'(dl[k])) begin
          dr[k+1][c] <= shifted[c] - RW'(dl[k]);
          dq[k+1][c] <= {dq[k][c][QW-2:0], 1'b1};
        end else begin
          dr[k+1][c] <= shifted[c];
          dq[k+1][c] <= {dq[k][c][QW-2:0], 1'b0};
        end
        dn[k+1][c] <= {dn[k][c][QW-2:0], 1'b0};
      end
      dl[k+1] <= dl[k];
      ds[k+1] <= ds[k];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      for (int s = 0; s < 33; s++) sv[s] <= 1'b0;
      for (int k = 0; k <= QW; k++) dv[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      b0_v  <= valid;
      sv[0] <= b0_v;
      for (int s = 0; s < 32; s++) sv[s+1] <= sv[s];
      dv[0] <= sv[32];
      for (int k = 0; k < QW; k++) dv[k+1] <= dv[k];
      done <= dv[QW];
    end
  end

  // sign the unit components or pass through
  always_comb begin
    logic [2:0][CW-1:0] o;
    for (int c = 0; c < 3; c++) begin
      if (ds[QW].norm && !ds[QW].zero)
        o[c] = ds[QW].r[c][CW-1] ? CW'(-$signed({1'b0, dq[QW][c]}))
                                 : CW'(dq[QW][c]);
      else
        o[c] = ds[QW].r[c];
    end
    result_next.out_x       = o[0];
    result_next.out_y       = o[1];
    result_next.out_z       = o[2];
    result_next.saturated   = ds[QW].sat;
    result_next.zero_normal = ds[QW].zero;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_zero_is_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_normal |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    else $error("zero normal with nonzero components");
  a_done_from_pipe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dv[QW])) else $error("result without a word in flight");

endmodule

FILE: src/affine_point_vector_normal_transform_top.sv
// Pipeline: an accepted word passes 56 registers before done rises, the first loaded
//   at the accepting edge (2 front stages, 1 queue, 2 square/sum, 32 root, 19 divide/out).
// Throughput: one word per cycle while busy is low; the root and divide units are
//   fully pipelined.
// Reset (rst, synchronous) empties the pipe and loads the identity matrix, mixed mode.
// The receiver cannot stall; done is a one-cycle strobe.
module affine_point_vector_normal_transform_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  apvn_pkg::in_word_t   item,
  output logic                 done,
  output apvn_pkg::out_word_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import apvn_pkg::*;

  cfg_t cfg;
  logic push;
  mid_t f_word;
  logic q_valid;
  logic q_full;
  mid_t q_word;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= 64'h0000_0000_0001_0000;
      cfg.row[1] <= '0;
      cfg.row[2] <= 64'h0001_0000_0000_0000;
      cfg.row[3] <= '0;
      cfg.row[4] <= '0;
      cfg.row[5] <= 64'h0000_0000_0001_0000;
      cfg.mode   <= MODE_MIXED;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < REG_MODE) cfg.row[cfg_index] <= cfg_data;
      else if (cfg_index == REG_MODE) cfg.mode <= mode_t'(cfg_data[1:0]);
    end
  end

  apvn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .item   (item),
    .cfg    (cfg),
    .push   (push),
    .word   (f_word)
  );

  apvn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_word),
    .pop   (1'b1),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_word)
  );

  apvn_back u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (q_valid),
    .word   (q_word),
    .done   (done),
    .result (result)
  );

endmodule
